/* rtl/spm_pkg.sv */
// package for the sparse polynomial multiplier: constants, types and codes
package spm_pkg;

  localparam int MAX_TERMS_DEF = 8;
  localparam int COEF_BITS_DEF = 16;
  localparam int EXP_BITS_DEF  = 10;
  localparam int IN_COEF_W     = 16;
  localparam int IN_EXP_W      = 10;
  localparam int OUT_COEF_W    = 40;
  localparam int OUT_EXP_W     = 11;
  localparam int SUM_DEPTH     = 64;
  localparam int SUM_IDX_W     = 6;
  localparam int SUM_CNT_W     = 7;

  typedef enum logic [1:0] {
    ACT_LOAD_FIRST  = 2'd0,
    ACT_LOAD_SECOND = 2'd1,
    ACT_MULTIPLY    = 2'd2,
    ACT_NONE        = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_SCAN,
    ST_EMIT_RD,
    ST_EMIT,
    ST_EMPTY
  } state_t;

endpackage

/* rtl/spm_if.sv */
// valid/ready channel interfaces for input and result transactions
interface spm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic signed [spm_pkg::IN_COEF_W-1:0] coefficient;
  logic [spm_pkg::IN_EXP_W-1:0] exponent;
  modport source (output valid, action, coefficient, exponent, input ready);
  modport sink   (input valid, action, coefficient, exponent, output ready);
endinterface

interface spm_out_if;
  logic valid;
  logic ready;
  logic signed [spm_pkg::OUT_COEF_W-1:0] product_coefficient;
  logic [spm_pkg::OUT_EXP_W-1:0] product_exponent;
  logic last_term;
  logic empty_product;
  logic overflow_seen;
  modport source (output valid, product_coefficient, product_exponent, last_term,
                  empty_product, overflow_seen, input ready);
  modport sink   (input valid, product_coefficient, product_exponent, last_term,
                  empty_product, overflow_seen, output ready);
endinterface

/* rtl/sparse_polynomial_multiplier.sv */
// top level of the sparse polynomial multiplier
//
// Input channel in: action 0/1 appends a term to the first/second operand,
// action 2 multiplies and emits, action 3 is ignored. A multiply walks
// every pair of terms; each product is merged into a result table held in
// one synchronous memory by a serial scan over the entries already held,
// one entry a cycle. Results leave on channel out, one term per
// transaction, the last marked with last_term; an empty operand gives
// one transaction with empty_product set. A stalled receiver holds the
// output register and the emit walk. No input is taken while a multiply
// runs. After emission both operands, the table and the drop flag clear;
// overflow_seen holds until the next multiply. Reset (rst_n, low,
// synchronous) empties all stores; no clearing pass is needed since
// entries are read only below their counts.
module sparse_polynomial_multiplier #(
  parameter int MAX_TERMS = spm_pkg::MAX_TERMS_DEF,
  parameter int COEF_BITS = spm_pkg::COEF_BITS_DEF,
  parameter int EXP_BITS  = spm_pkg::EXP_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  spm_in_if.sink   in_ch,
  spm_out_if.source out_ch
);
  localparam int TW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int SW = EXP_BITS + 1;
  localparam int PW = 2 * COEF_BITS;

  // operand stores
  logic signed [COEF_BITS-1:0] f_coef [MAX_TERMS];
  logic [EXP_BITS-1:0] f_exp [MAX_TERMS];
  logic signed [COEF_BITS-1:0] s_coef [MAX_TERMS];
  logic [EXP_BITS-1:0] s_exp [MAX_TERMS];
  // result table memory
  logic [spm_pkg::OUT_COEF_W-1:0] t_coef [spm_pkg::SUM_DEPTH];
  logic [SW-1:0] t_exp [spm_pkg::SUM_DEPTH];

  spm_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] fcnt_r, scnt_r;
  logic [TW-1:0] i_r, j_r;
  logic [spm_pkg::SUM_CNT_W-1:0] tcnt_r, k_r;
  logic drop_r;
  logic signed [PW-1:0] prod_r;
  logic [SW-1:0] pexp_r;
  logic [spm_pkg::OUT_COEF_W-1:0] rd_coef_r;
  logic [SW-1:0] rd_exp_r;
  logic rd_ok_r;
  logic ov_r;

  logic acc_in, out_fire;
  logic last_pair, hit;
  logic [spm_pkg::OUT_COEF_W-1:0] prod_ext;

  assign acc_in   = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == spm_pkg::ST_IDLE);
  assign last_pair = (i_r == TW'(fcnt_r - 1'b1)) &&
                     (j_r == TW'(scnt_r - 1'b1));
  assign hit = rd_ok_r && (rd_exp_r == pexp_r);
  assign prod_ext = spm_pkg::OUT_COEF_W'(prod_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spm_pkg::ST_IDLE: begin
        if (acc_in && in_ch.action == spm_pkg::ACT_MULTIPLY) begin
          if (fcnt_r == '0 || scnt_r == '0) state_nxt = spm_pkg::ST_EMPTY;
          else state_nxt = spm_pkg::ST_PROD;
        end
      end
      spm_pkg::ST_PROD: state_nxt = spm_pkg::ST_SCAN;
      spm_pkg::ST_SCAN: begin
        if (hit || k_r >= tcnt_r) begin
          if (last_pair) state_nxt = spm_pkg::ST_EMIT_RD;
          else state_nxt = spm_pkg::ST_PROD;
        end
      end
      spm_pkg::ST_EMIT_RD: state_nxt = spm_pkg::ST_EMIT;
      spm_pkg::ST_EMIT: begin
        if (out_fire) begin
          if (k_r == tcnt_r) state_nxt = spm_pkg::ST_IDLE;
          else state_nxt = spm_pkg::ST_EMIT_RD;
        end
      end
      spm_pkg::ST_EMPTY: if (out_fire) state_nxt = spm_pkg::ST_IDLE;
      default: state_nxt = spm_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    out_ch.valid = 1'b0;
    out_ch.product_coefficient = '0;
    out_ch.product_exponent = '0;
    out_ch.last_term = 1'b0;
    out_ch.empty_product = 1'b0;
    out_ch.overflow_seen = ov_r;
    case (state_r)
      spm_pkg::ST_EMIT: begin
        out_ch.valid = 1'b1;
        out_ch.product_coefficient = rd_coef_r;
        out_ch.product_exponent = spm_pkg::OUT_EXP_W'(rd_exp_r);
        out_ch.last_term = (k_r == tcnt_r);
      end
      spm_pkg::ST_EMPTY: begin
        out_ch.valid = 1'b1;
        out_ch.last_term = 1'b1;
        out_ch.empty_product = 1'b1;
      end
      default: out_ch.valid = 1'b0;
    endcase
  end

  // operand stores and product register
  always_ff @(posedge clk) begin
    if (acc_in && in_ch.action == spm_pkg::ACT_LOAD_FIRST && fcnt_r < CW'(MAX_TERMS)) begin
      f_coef[TW'(fcnt_r)] <= COEF_BITS'(in_ch.coefficient);
      f_exp[TW'(fcnt_r)]  <= EXP_BITS'(in_ch.exponent);
    end
    if (acc_in && in_ch.action == spm_pkg::ACT_LOAD_SECOND && scnt_r < CW'(MAX_TERMS)) begin
      s_coef[TW'(scnt_r)] <= COEF_BITS'(in_ch.coefficient);
      s_exp[TW'(scnt_r)]  <= EXP_BITS'(in_ch.exponent);
    end
    if (state_r == spm_pkg::ST_PROD) begin
      prod_r <= PW'(f_coef[i_r]) * PW'(s_coef[j_r]);
      pexp_r <= SW'(f_exp[i_r]) + SW'(s_exp[j_r]);
    end
  end

  // table memory: write port and registered read, held while a term waits
  always_ff @(posedge clk) begin
    if (state_r == spm_pkg::ST_SCAN) begin
      if (hit) t_coef[k_r[spm_pkg::SUM_IDX_W-1:0] - 1'b1] <= rd_coef_r + prod_ext;
      else if (k_r >= tcnt_r && tcnt_r < spm_pkg::SUM_CNT_W'(spm_pkg::SUM_DEPTH)) begin
        t_coef[tcnt_r[spm_pkg::SUM_IDX_W-1:0]] <= prod_ext;
        t_exp[tcnt_r[spm_pkg::SUM_IDX_W-1:0]]  <= pexp_r;
      end
    end
    if (state_r != spm_pkg::ST_EMIT) begin
      rd_coef_r <= t_coef[k_r[spm_pkg::SUM_IDX_W-1:0]];
      rd_exp_r  <= t_exp[k_r[spm_pkg::SUM_IDX_W-1:0]];
    end
  end

  // control registers; the scan reads entry k, compares it in the cycle after
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spm_pkg::ST_IDLE;
      fcnt_r <= '0; scnt_r <= '0; tcnt_r <= '0; k_r <= '0;
      i_r <= '0; j_r <= '0; drop_r <= 1'b0; rd_ok_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_ok_r <= 1'b0;
      case (state_r)
        spm_pkg::ST_IDLE: begin
          k_r <= '0;
          if (acc_in && in_ch.action == spm_pkg::ACT_LOAD_FIRST) begin
            if (fcnt_r < CW'(MAX_TERMS)) fcnt_r <= fcnt_r + 1'b1;
            else drop_r <= 1'b1;
          end
          if (acc_in && in_ch.action == spm_pkg::ACT_LOAD_SECOND) begin
            if (scnt_r < CW'(MAX_TERMS)) scnt_r <= scnt_r + 1'b1;
            else drop_r <= 1'b1;
          end
          if (acc_in && in_ch.action == spm_pkg::ACT_MULTIPLY) begin
            i_r <= '0; j_r <= '0; tcnt_r <= '0; ov_r <= drop_r;
          end
        end
        spm_pkg::ST_PROD: begin
          k_r <= spm_pkg::SUM_CNT_W'(1);
          rd_ok_r <= (tcnt_r != '0);
        end
        spm_pkg::ST_SCAN: begin
          if (hit || k_r >= tcnt_r) begin
            if (!hit) begin
              if (tcnt_r < spm_pkg::SUM_CNT_W'(spm_pkg::SUM_DEPTH)) tcnt_r <= tcnt_r + 1'b1;
              else begin drop_r <= 1'b1; ov_r <= 1'b1; end
            end
            k_r <= '0;
            if (j_r == TW'(scnt_r - 1'b1)) begin
              j_r <= '0; i_r <= i_r + 1'b1;
            end else j_r <= j_r + 1'b1;
          end else begin
            k_r <= k_r + 1'b1;
            rd_ok_r <= 1'b1;
          end
        end
        spm_pkg::ST_EMIT_RD: k_r <= k_r + 1'b1;
        spm_pkg::ST_EMIT: begin
          if (out_fire && k_r == tcnt_r) begin
            fcnt_r <= '0; scnt_r <= '0; tcnt_r <= '0; drop_r <= 1'b0;
          end
        end
        spm_pkg::ST_EMPTY: begin
          if (out_fire) begin
            fcnt_r <= '0; scnt_r <= '0; drop_r <= 1'b0;
          end
        end
        default: k_r <= '0;
      endcase
    end
  end

  // checks
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != spm_pkg::ST_IDLE |-> !in_ch.ready) else $error("input taken while busy");
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= CW'(MAX_TERMS) && scnt_r <= CW'(MAX_TERMS)) else $error("count overrun");
  a_tbl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= spm_pkg::SUM_CNT_W'(spm_pkg::SUM_DEPTH)) else $error("table overrun");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.last_term |=> fcnt_r == '0 && scnt_r == '0 && !drop_r)
    else $error("stores not cleared");
endmodule

/* tb/sv/sparse_polynomial_multiplier_tb.sv */
// testbench for the sparse polynomial multiplier: directed table, random sequences, predictor
module sparse_polynomial_multiplier_tb;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int RANDOM_ITEMS = 100;
  localparam int DRAIN_CYCLES = 50;

  typedef struct {
    logic signed [spm_pkg::OUT_COEF_W-1:0] coef;
    logic [spm_pkg::OUT_EXP_W-1:0]         expo;
    bit                                    last;
    bit                                    empty;
    bit                                    ovf;
  } term_t;

  typedef struct {
    spm_pkg::action_t                     act;
    logic signed [spm_pkg::IN_COEF_W-1:0] coef;
    logic [spm_pkg::IN_EXP_W-1:0]         expo;
    bit                                   typed;
    term_t                                res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  spm_in_if  in_ch();
  spm_out_if out_ch();

  sparse_polynomial_multiplier dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  // predictor copy of the operand stores and the overflow flag
  logic signed [spm_pkg::IN_COEF_W-1:0] p_first_c[spm_pkg::MAX_TERMS_DEF];
  logic [spm_pkg::IN_EXP_W-1:0]         p_first_e[spm_pkg::MAX_TERMS_DEF];
  logic signed [spm_pkg::IN_COEF_W-1:0] p_second_c[spm_pkg::MAX_TERMS_DEF];
  logic [spm_pkg::IN_EXP_W-1:0]         p_second_e[spm_pkg::MAX_TERMS_DEF];
  int  p_first_n = 0;
  int  p_second_n = 0;
  bit  p_dropped = 1'b0;

  term_t expected_terms[$];
  row_t  dir_rows[$];
  int    errors = 0;
  int    cycles = 0;
  int    in_idle = 6;
  int    out_idle = 71;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // work out the product terms a transaction causes
  task automatic multiply_predict(input spm_pkg::action_t act,
                                  input logic signed [spm_pkg::IN_COEF_W-1:0] c,
                                  input logic [spm_pkg::IN_EXP_W-1:0] e);
    logic signed [spm_pkg::OUT_COEF_W-1:0] sum_c[$];
    logic [spm_pkg::OUT_EXP_W-1:0]         sum_e[$];
    logic signed [spm_pkg::OUT_COEF_W-1:0] prod;
    logic [spm_pkg::OUT_EXP_W-1:0]         esum;
    bit                                    hit;
    term_t                                 t;
    case (act)
      spm_pkg::ACT_LOAD_FIRST: begin
        if (p_first_n < spm_pkg::MAX_TERMS_DEF) begin
          p_first_c[p_first_n] = c;
          p_first_e[p_first_n] = e;
          p_first_n++;
        end else p_dropped = 1'b1;
      end
      spm_pkg::ACT_LOAD_SECOND: begin
        if (p_second_n < spm_pkg::MAX_TERMS_DEF) begin
          p_second_c[p_second_n] = c;
          p_second_e[p_second_n] = e;
          p_second_n++;
        end else p_dropped = 1'b1;
      end
      spm_pkg::ACT_MULTIPLY: begin
        for (int i = 0; i < p_first_n; i++)
          for (int j = 0; j < p_second_n; j++) begin
            prod = p_first_c[i] * p_second_c[j];
            esum = {1'b0, p_first_e[i]} + {1'b0, p_second_e[j]};
            hit = 1'b0;
            foreach (sum_e[k])
              if (!hit && sum_e[k] == esum) begin
                sum_c[k] += prod;
                hit = 1'b1;
              end
            if (!hit) begin
              if (sum_e.size() < spm_pkg::SUM_DEPTH) begin
                sum_c.push_back(prod);
                sum_e.push_back(esum);
              end else p_dropped = 1'b1;
            end
          end
        if (sum_e.size() == 0) begin
          t = '{coef: '0, expo: '0, last: 1'b1, empty: 1'b1, ovf: p_dropped};
          expected_terms.push_back(t);
        end else begin
          foreach (sum_e[k]) begin
            t = '{coef: sum_c[k], expo: sum_e[k], last: (k == sum_e.size() - 1),
                  empty: 1'b0, ovf: p_dropped};
            expected_terms.push_back(t);
          end
        end
        p_first_n = 0;
        p_second_n = 0;
        p_dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  // drive one input transaction, idling first at random
  task automatic send_item(input row_t r);
    while ($urandom_range(99) < in_idle) begin
      @(negedge clk) in_ch.valid = 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.action = r.act;
    in_ch.coefficient = r.coef;
    in_ch.exponent = r.expo;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    multiply_predict(r.act, r.coef, r.expo);
    if (r.typed) begin
      void'(expected_terms.pop_back());
      expected_terms.push_back(r.res);
    end
  endtask

  task automatic add_row(input spm_pkg::action_t act, input int c, input int e);
    row_t r;
    r.act = act;
    r.coef = c[spm_pkg::IN_COEF_W-1:0];
    r.expo = e[spm_pkg::IN_EXP_W-1:0];
    r.typed = 1'b0;
    r.res = '{coef: '0, expo: '0, last: 1'b0, empty: 1'b0, ovf: 1'b0};
    dir_rows.push_back(r);
  endtask

  task automatic add_typed(input logic signed [spm_pkg::OUT_COEF_W-1:0] c, input int e,
                           input bit emp);
    row_t r;
    r.act = spm_pkg::ACT_MULTIPLY;
    r.coef = '0;
    r.expo = '0;
    r.typed = 1'b1;
    r.res = '{coef: c, expo: e[spm_pkg::OUT_EXP_W-1:0], last: 1'b1, empty: emp, ovf: 1'b0};
    dir_rows.push_back(r);
  endtask

  // receiver stalls at random
  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= out_idle);

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    term_t x;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_terms.size() == 0) begin
        $error("unexpected result: coef %0d expo %0d", out_ch.product_coefficient,
               out_ch.product_exponent);
        errors++;
      end else begin
        x = expected_terms.pop_front();
        if (out_ch.product_coefficient !== x.coef) begin
          $error("product_coefficient: expected %0d, got %0d", x.coef,
                 out_ch.product_coefficient);
          errors++;
        end
        if (out_ch.product_exponent !== x.expo) begin
          $error("product_exponent: expected %0d, got %0d", x.expo, out_ch.product_exponent);
          errors++;
        end
        if (out_ch.last_term !== x.last) begin
          $error("last_term: expected %0d, got %0d", x.last, out_ch.last_term);
          errors++;
        end
        if (out_ch.empty_product !== x.empty) begin
          $error("empty_product: expected %0d, got %0d", x.empty, out_ch.empty_product);
          errors++;
        end
        if (out_ch.overflow_seen !== x.ovf) begin
          $error("overflow_seen: expected %0d, got %0d", x.ovf, out_ch.overflow_seen);
          errors++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    row_t r;
    int   sent;
    int   n1;
    int   n2;
    int   total;
    bit   narrow;
    int   pick;
    in_ch.valid = 1'b0;
    in_ch.action = spm_pkg::ACT_NONE;
    in_ch.coefficient = '0;
    in_ch.exponent = '0;
    out_ch.ready = 1'b0;

    // directed table: empty operands, extremes, store overflow, cancellation
    add_typed(40'sd0, 0, 1'b1);
    add_row(spm_pkg::ACT_LOAD_FIRST, 5, 3);
    add_typed(40'sd0, 0, 1'b1);
    add_row(spm_pkg::ACT_LOAD_FIRST, -32768, 1023);
    add_row(spm_pkg::ACT_LOAD_SECOND, -32768, 1023);
    add_typed(40'sd1073741824, 2046, 1'b0);
    add_row(spm_pkg::ACT_LOAD_FIRST, 32767, 0);
    add_row(spm_pkg::ACT_LOAD_SECOND, -32768, 1023);
    add_typed(-40'sd1073709056, 1023, 1'b0);
    for (int k = 0; k < 9; k++) add_row(spm_pkg::ACT_LOAD_FIRST, k + 1, k);
    add_row(spm_pkg::ACT_LOAD_SECOND, 1, 0);
    add_row(spm_pkg::ACT_NONE, -1, 1023);
    add_row(spm_pkg::ACT_MULTIPLY, 0, 0);
    add_row(spm_pkg::ACT_LOAD_FIRST, 1, 0);
    add_row(spm_pkg::ACT_LOAD_FIRST, -1, 1);
    add_row(spm_pkg::ACT_LOAD_SECOND, 1, 1);
    add_row(spm_pkg::ACT_LOAD_SECOND, 1, 0);
    add_row(spm_pkg::ACT_MULTIPLY, 0, 0);

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    foreach (dir_rows[k]) send_item(dir_rows[k]);

    // random operand pairs with random content, then a multiply
    sent = 0;
    total = RANDOM_ITEMS;
    while (sent < total) begin
      if (sent > 2 * total / 3) begin
        in_idle = 0;
        out_idle = 0;
      end else if (sent > total / 3) begin
        in_idle = 71;
        out_idle = 6;
      end
      n1 = ($urandom_range(9) == 0) ? 9 * $urandom_range(1) : $urandom_range(8, 1);
      n2 = ($urandom_range(9) == 0) ? 9 * $urandom_range(1) : $urandom_range(8, 1);
      narrow = $urandom_range(1);
      while (n1 + n2 > 0) begin
        pick = $urandom_range(n1 + n2 - 1);
        r.typed = 1'b0;
        r.act = (pick < n1) ? spm_pkg::ACT_LOAD_FIRST : spm_pkg::ACT_LOAD_SECOND;
        if (pick < n1) n1--;
        else n2--;
        r.coef = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'sh8000 : 16'sh7fff)
                                          : spm_pkg::IN_COEF_W'($urandom);
        r.expo = narrow ? spm_pkg::IN_EXP_W'($urandom_range(7))
                        : spm_pkg::IN_EXP_W'($urandom_range(1023));
        if ($urandom_range(19) == 0) r.act = spm_pkg::ACT_NONE;
        else sent++;
        send_item(r);
      end
      r.act = spm_pkg::ACT_MULTIPLY;
      r.coef = spm_pkg::IN_COEF_W'($urandom);
      r.expo = spm_pkg::IN_EXP_W'($urandom);
      r.typed = 1'b0;
      send_item(r);
      sent++;
    end
    @(negedge clk) in_ch.valid = 1'b0;

    while (expected_terms.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
